### sv/depth_difference_nearest_pixel_unit_macros.svh
// Assertion helpers for the file that checks this block.
`ifndef DEPTH_DIFFERENCE_NEAREST_PIXEL_UNIT_MACROS_SVH
`define DEPTH_DIFFERENCE_NEAREST_PIXEL_UNIT_MACROS_SVH

// Same-cycle implication, checked on i_clk, off while i_rst_n is low.
`define DDNP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off while i_rst_n is low.
`define DDNP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ddnp_pkg.sv
package ddnp_pkg;

    // Image geometry and depth format
    localparam int IMAGE_WIDTH  = 512;
    localparam int IMAGE_HEIGHT = 512;
    localparam int DEPTH_BITS   = 24;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int ADDR_W   = 18;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int DIFF_W   = 25;
    localparam int COL_W    = $clog2(IMAGE_WIDTH);
    localparam int ROW_W    = ADDR_W;
    localparam int COLOFF_W = 9;
    localparam int ROWOFF_W = 10;
    localparam int COORD_W  = 33;
    localparam int SCALE_W  = 24;
    localparam int PROD_W   = ROWOFF_W + SCALE_W + 1;
    localparam int OUT_DATA_W = 128;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    // Far-plane code, all ones at DEPTH_BITS
    localparam logic [32:0] FAR_PLANE = (33'd1 << DEPTH_BITS) - 33'd1;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic                     compare;
        logic                     last;
        logic                     far;
        logic [ADDR_W-1:0]        idx;
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         row;
        logic signed [DIFF_W-1:0] diff;
    } t_item;

    // Queue status seen by the front
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              push;
    } t_q_status;

    // Frame result before scaling
    typedef struct packed {
        logic                       found;
        logic [ADDR_W-1:0]          idx;
        logic signed [COLOFF_W-1:0] col_off;
        logic signed [ROWOFF_W-1:0] row_off;
        logic signed [DIFF_W-1:0]   min_diff;
    } t_result;

endpackage

### sv/depth_difference_nearest_pixel_unit.sv
// A result becomes valid on m_axis after a compare-mode last pixel is taken, passing through the
//   read stage, queue entry, result stage, then the output register.
// Throughput: one sample per cycle; the reference store's single port serves one load or one read.
// Back-pressure on m_axis fills a 4-entry queue before s_axis_tready drops.
// Reset (i_rst_n low, synchronous): position, best tracking, queue and output clear;
//   inv_scale = 1.0. The reference store is not cleared and must be loaded first.
`include "depth_difference_nearest_pixel_unit_macros.svh"

module depth_difference_nearest_pixel_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration
    input  logic                                i_cfg_wr_en,
    input  logic [ddnp_pkg::SCALE_W-1:0]        i_cfg_wr_data,   // inv_scale, Q8.16
    // Sample stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ddnp_pkg::SAMPLE_W-1:0]       s_axis_tdata,    // [23:0] depth_sample
    input  logic                                s_axis_tuser,    // [0] mode
    input  logic                                s_axis_tlast,    // last_pixel
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [17:0] pixel_index, [26:18] column_offset, [36:27] row_offset,
    // [69:37] x_coord, [102:70] y_coord, [127:103] min_difference
    output logic [ddnp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser     // [0] found
);

    logic [ddnp_pkg::SCALE_W-1:0] r_inv_scale;

    logic                 push;
    ddnp_pkg::t_item      push_item;
    logic                 pop;
    logic                 q_valid;
    ddnp_pkg::t_item      q_item;
    ddnp_pkg::t_q_status  q_status;

    // Scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_scale <= ddnp_pkg::SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            r_inv_scale <= i_cfg_wr_data;
        end
    end

    ddnp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_compare (s_axis_tuser),
        .i_sample  (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_ready   (s_axis_tready),
        .i_q_count (q_status.count),
        .o_push    (push),
        .o_item    (push_item)
    );

    ddnp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_item   (q_item),
        .o_status (q_status)
    );

    ddnp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .i_inv_scale (r_inv_scale),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_found     (m_axis_tuser),
        .o_data      (m_axis_tdata)
    );

    // Credit scheme must never push into a full queue
    `DDNP_ASSERT_IMP(a_no_push_full, q_status.push, q_status.count < ddnp_pkg::QCNT_W'(ddnp_pkg::QUEUE_DEPTH), "push into full queue")
    // Back side only pops a filled queue
    `DDNP_ASSERT_IMP(a_no_pop_empty, pop, q_status.count != '0, "pop from empty queue")
    // With nothing found the difference field is zero
    `DDNP_ASSERT_IMP(a_empty_diff, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[127:103] == '0, "min_difference set without a found pixel")

endmodule

### sv/ddnp_ram.sv
module ddnp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ddnp_front.sv
module ddnp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_compare,
    input  logic [ddnp_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                           i_last,
    output logic                           o_ready,
    input  logic [ddnp_pkg::QCNT_W-1:0]    i_q_count,
    output logic                           o_push,
    output ddnp_pkg::t_item                o_item
);

    logic                          accept;
    logic [ddnp_pkg::QCNT_W-1:0]   credit;
    logic [ddnp_pkg::SAMPLE_W-1:0] rdata;

    // Raster position counters
    logic [ddnp_pkg::ADDR_W-1:0] r_pos, n_pos;
    logic [ddnp_pkg::COL_W-1:0]  r_col, n_col;
    logic [ddnp_pkg::ROW_W-1:0]  r_row, n_row;

    // Stage waiting for the reference read
    logic                          r_stg_valid;
    logic                          r_stg_compare;
    logic                          r_stg_last;
    logic [ddnp_pkg::SAMPLE_W-1:0] r_stg_sample;
    logic [ddnp_pkg::ADDR_W-1:0]   r_stg_idx;
    logic [ddnp_pkg::COL_W-1:0]    r_stg_col;
    logic [ddnp_pkg::ROW_W-1:0]    r_stg_row;

    // Take a sample only if the queue can hold it and the one in flight
    assign credit  = i_q_count + ddnp_pkg::QCNT_W'(r_stg_valid);
    assign o_ready = credit < ddnp_pkg::QCNT_W'(ddnp_pkg::QUEUE_DEPTH);
    assign accept  = i_valid && o_ready;

    // Next position: restart on last or after the image's final pixel, column/row step otherwise
    always_comb begin
        n_pos = r_pos;
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (i_last || (r_pos == '1)) begin
                n_pos = '0;
                n_col = '0;
                n_row = '0;
            end else begin
                n_pos = r_pos + 1'b1;
                if (r_col == ddnp_pkg::COL_W'(ddnp_pkg::IMAGE_WIDTH - 1)) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_stg_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_col       <= n_col;
            r_row       <= n_row;
            r_stg_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stg_compare <= i_compare;
            r_stg_last    <= i_last;
            r_stg_sample  <= i_sample;
            r_stg_idx     <= r_pos;
            r_stg_col     <= r_col;
            r_stg_row     <= r_row;
        end
    end

    // Reference store: loads write, compares read
    ddnp_ram #(
        .WIDTH (ddnp_pkg::SAMPLE_W),
        .DEPTH (ddnp_pkg::STORE_DEPTH)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (accept && !i_compare),
        .i_addr  (r_pos),
        .i_wdata (i_sample),
        .o_rdata (rdata)
    );

    // Classify: difference against reference and far-plane check
    always_comb begin
        o_item.compare = r_stg_compare;
        o_item.last    = r_stg_last;
        o_item.far     = ({(33 - ddnp_pkg::SAMPLE_W)'(0), rdata} == ddnp_pkg::FAR_PLANE);
        o_item.idx     = r_stg_idx;
        o_item.col     = r_stg_col;
        o_item.row     = r_stg_row;
        o_item.diff    = $signed({1'b0, r_stg_sample}) - $signed({1'b0, rdata});
    end

    assign o_push = r_stg_valid;

endmodule

### sv/ddnp_queue.sv
module ddnp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ddnp_pkg::t_item       i_item,
    input  logic                  i_pop,
    output logic                  o_valid,
    output ddnp_pkg::t_item       o_item,
    output ddnp_pkg::t_q_status   o_status
);

    ddnp_pkg::t_item                r_mem [ddnp_pkg::QUEUE_DEPTH];
    logic [ddnp_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [ddnp_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [ddnp_pkg::QCNT_W-1:0]    r_count;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + ddnp_pkg::QCNT_W'(i_push) - ddnp_pkg::QCNT_W'(i_pop);
        end
    end

    assign o_valid        = (r_count != '0);
    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.push  = i_push;

endmodule

### sv/ddnp_back.sv
module ddnp_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  ddnp_pkg::t_item                       i_q_item,
    output logic                                  o_pop,
    input  logic [ddnp_pkg::SCALE_W-1:0]          i_inv_scale,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_found,
    output logic [ddnp_pkg::OUT_DATA_W-1:0]       o_data
);

    // Running best of the frame
    logic                               r_best_valid;
    logic signed [ddnp_pkg::DIFF_W-1:0] r_best_diff;
    logic [ddnp_pkg::ADDR_W-1:0]        r_best_idx;
    logic [ddnp_pkg::COL_W-1:0]         r_best_col;
    logic [ddnp_pkg::ROW_W-1:0]         r_best_row;

    logic                               take;
    logic                               upd_valid;
    logic signed [ddnp_pkg::DIFF_W-1:0] upd_diff;
    logic [ddnp_pkg::ADDR_W-1:0]        upd_idx;
    logic [ddnp_pkg::COL_W-1:0]         upd_col;
    logic [ddnp_pkg::ROW_W-1:0]         upd_row;
    logic [ddnp_pkg::ADDR_W-1:0]        col_full;
    logic [ddnp_pkg::ROW_W-1:0]         row_full;

    logic               produce;
    logic               out_free;
    logic               res_adv;
    logic               res_ready;
    ddnp_pkg::t_result  n_res;

    // Result stage and output register
    logic               r_res_valid;
    ddnp_pkg::t_result  r_res;
    logic               r_out_valid;
    logic               r_out_found;
    logic [ddnp_pkg::OUT_DATA_W-1:0] r_out_data;

    logic signed [ddnp_pkg::SCALE_W:0]  scale_s;
    logic signed [ddnp_pkg::PROD_W-1:0] x_prod;
    logic signed [ddnp_pkg::PROD_W-1:0] y_prod;

    // Handshake between queue, result stage and output
    assign out_free  = !r_out_valid || i_ready;
    assign res_adv   = r_res_valid && out_free;
    assign res_ready = !r_res_valid || out_free;
    assign produce   = i_q_item.compare && i_q_item.last;
    assign o_pop     = i_q_valid && (!produce || res_ready);

    // Best update: strict less-than keeps the earlier pixel on ties
    assign take = i_q_item.compare && !i_q_item.far &&
                  (!r_best_valid || (i_q_item.diff < r_best_diff));

    always_comb begin
        upd_valid = r_best_valid || take;
        upd_diff  = take ? i_q_item.diff : r_best_diff;
        upd_idx   = take ? i_q_item.idx  : r_best_idx;
        upd_col   = take ? i_q_item.col  : r_best_col;
        upd_row   = take ? i_q_item.row  : r_best_row;
    end

    // Centred offsets, wrapped to their field widths
    always_comb begin
        col_full = ddnp_pkg::ADDR_W'(upd_col) - ddnp_pkg::ADDR_W'(ddnp_pkg::IMAGE_WIDTH / 2);
        row_full = upd_row + ddnp_pkg::ROW_W'(1) -
                   ddnp_pkg::ROW_W'(ddnp_pkg::IMAGE_HEIGHT / 2);
        n_res.found    = upd_valid;
        n_res.idx      = upd_idx;
        n_res.col_off  = col_full[ddnp_pkg::COLOFF_W-1:0];
        n_res.row_off  = row_full[ddnp_pkg::ROWOFF_W-1:0];
        n_res.min_diff = upd_valid ? upd_diff : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_best_diff  <= '0;
            r_best_idx   <= '0;
            r_best_col   <= '0;
            r_best_row   <= '0;
        end else if (o_pop) begin
            r_best_idx <= upd_idx;
            r_best_col <= upd_col;
            r_best_row <= upd_row;
            if (i_q_item.last) begin
                r_best_valid <= 1'b0;
                r_best_diff  <= '0;
            end else begin
                r_best_valid <= upd_valid;
                r_best_diff  <= upd_diff;
            end
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_pop && produce) begin
            r_res_valid <= 1'b1;
        end else if (res_adv) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && produce) begin
            r_res <= n_res;
        end
    end

    // Scale by the reciprocal, then register
    assign scale_s = $signed({1'b0, i_inv_scale});
    assign x_prod  = ddnp_pkg::PROD_W'(r_res.col_off) * ddnp_pkg::PROD_W'(scale_s);
    assign y_prod  = ddnp_pkg::PROD_W'(r_res.row_off) * ddnp_pkg::PROD_W'(scale_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_adv) begin
            r_out_found <= r_res.found;
            r_out_data  <= {r_res.min_diff,
                            y_prod[ddnp_pkg::COORD_W-1:0],
                            x_prod[ddnp_pkg::COORD_W-1:0],
                            r_res.row_off,
                            r_res.col_off,
                            r_res.idx};
        end
    end

    assign o_valid = r_out_valid;
    assign o_found = r_out_found;
    assign o_data  = r_out_data;

endmodule
